FILE: design/bc_pkg.sv
// Shared types, widths and status codes for the binomial coefficient block.
`default_nettype none

package bc_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int N_WIDTH     = 7;
   localparam int PROD_WIDTH  = VALUE_WIDTH + N_WIDTH;
   localparam int CNT_WIDTH   = $clog2(PROD_WIDTH + 1);
   localparam int STAT_WIDTH  = 2;

   localparam logic [STAT_WIDTH-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_WIDTH-1:0] STATUS_K_GT_N   = 2'd1;
   localparam logic [STAT_WIDTH-1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [N_WIDTH-1:0] n_total;
      logic [N_WIDTH-1:0] k_chosen;
   } req_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] coefficient;
      logic [STAT_WIDTH-1:0]  status;
   } rsp_type;

endpackage

`default_nettype wire

FILE: design/binomial_coefficient.sv
// Binomial coefficient C(n,k): sequencer around a shared multiply and bit-serial divider.
//
// One item at a time: an item is taken when start is high and busy is low, and
// its result appears on rsp_data for exactly one cycle with rsp_valid high; the
// receiver cannot stall, so it must take the result in that cycle. The block
// runs min(k, n-k) steps; each step multiplies the running value by (n-i) and
// divides the 71-bit product by (i+1) in the shared divider, one quotient bit
// per cycle. The steps run are min(k, n-k), or fewer when a step overflows and
// the block stops there. The longest item runs 33 steps (C(66,33), C(67,33) or
// C(67,34)). When k > n the result is status 1; when any step's value exceeds
// 64 bits the result is status 2; the coefficient is zero in both cases. busy
// drops in the same cycle as the result strobe, so the next item can be taken
// right away.
`default_nettype none

module binomial_coefficient import bc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_ISSUE = 2'd2;
   localparam logic [1:0] ST_WAIT  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [N_WIDTH-1:0]     n_ff, n_in;
   logic [N_WIDTH-1:0]     k_ff, k_in;
   logic [N_WIDTH-1:0]     limit_ff, limit_in;
   logic [N_WIDTH-1:0]     idx_ff, idx_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [N_WIDTH-1:0]     n_minus_k;
   logic [N_WIDTH-1:0]     limit_calc;
   logic [N_WIDTH-1:0]     idx_next;
   logic [PROD_WIDTH-1:0]  product;
   logic                   div_start;
   logic                   div_done;
   logic [PROD_WIDTH-1:0]  div_quotient;
   logic                   too_big;

   // Form the step product and the step bounds
   always_comb begin
      n_minus_k  = n_ff - k_ff;
      limit_calc = (k_ff < n_minus_k) ? k_ff : n_minus_k;
      idx_next   = idx_ff + 1'b1;
      product    = PROD_WIDTH'(value_ff) * PROD_WIDTH'(n_ff - idx_ff);
      too_big    = |div_quotient[PROD_WIDTH-1:VALUE_WIDTH];
   end

   bc_divider u_div (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (product),
      .div_divisor  (idx_next),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   // Sequence the steps of one item
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      limit_in     = limit_ff;
      idx_in       = idx_ff;
      value_in     = value_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in     = req_data.n_total;
               k_in     = req_data.k_chosen;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (k_ff > n_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_in.coefficient = '0;
               rsp_in.status      = STATUS_K_GT_N;
               state_in           = ST_IDLE;
            end else if (limit_calc == '0) begin
               rsp_valid_in       = 1'b1;
               rsp_in.coefficient = VALUE_WIDTH'(1);
               rsp_in.status      = STATUS_OK;
               state_in           = ST_IDLE;
            end else begin
               limit_in = limit_calc;
               idx_in   = '0;
               value_in = VALUE_WIDTH'(1);
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               if (too_big) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.coefficient = '0;
                  rsp_in.status      = STATUS_OVERFLOW;
                  state_in           = ST_IDLE;
               end else if (idx_next == limit_ff) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.coefficient = div_quotient[VALUE_WIDTH-1:0];
                  rsp_in.status      = STATUS_OK;
                  state_in           = ST_IDLE;
               end else begin
                  value_in = div_quotient[VALUE_WIDTH-1:0];
                  idx_in   = idx_next;
                  state_in = ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      k_ff     <= k_in;
      limit_ff <= limit_in;
      idx_ff   <= idx_in;
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: design/bc_divider.sv
// Restoring divider: wide product by a narrow divisor, one quotient bit per cycle.
`default_nettype none

module bc_divider import bc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  div_start,
   input  wire logic [PROD_WIDTH-1:0] div_dividend,
   input  wire logic [N_WIDTH-1:0]    div_divisor,
   output logic                       div_done,
   output logic [PROD_WIDTH-1:0]      div_quotient
);

   logic [PROD_WIDTH-1:0] quo_ff, quo_in;
   logic [N_WIDTH-1:0]    rem_ff, rem_in;
   logic [N_WIDTH-1:0]    dvs_ff, dvs_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;

   logic [N_WIDTH:0]      shifted;
   logic [N_WIDTH:0]      diff;
   logic                  fits;

   // Shift in the next dividend bit and try to subtract the divisor
   always_comb begin
      shifted = {rem_ff, quo_ff[PROD_WIDTH-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});
   end

   // Advance one bit per cycle while running
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_start) begin
         quo_in = div_dividend;
         rem_in = '0;
         dvs_in = div_divisor;
         cnt_in = CNT_WIDTH'(PROD_WIDTH);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[PROD_WIDTH-2:0], fits};
         rem_in = fits ? diff[N_WIDTH-1:0] : shifted[N_WIDTH-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_WIDTH'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_done     = done_ff;
   assign div_quotient = quo_ff;

endmodule

`default_nettype wire

FILE: design/bc_checker.sv
// Port-level checks for the binomial coefficient block, bound to the top level.
`default_nettype none

module bc_checker import bc_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   // An accepted item raises busy in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // Busy drops only together with a result strobe
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // A result strobe lasts one cycle and never overlaps busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy ##1 !rsp_valid))
      else $error("result strobe overlapped busy or repeated");

   // Error results carry a zero coefficient
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |-> (rsp_data.coefficient == '0))
      else $error("error result with nonzero coefficient");

   // Status is one of the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK || rsp_data.status == STATUS_K_GT_N ||
                     rsp_data.status == STATUS_OVERFLOW))
      else $error("undefined status code");

endmodule

bind binomial_coefficient bc_checker u_bc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: dv/binomial_coefficient_checker.sv
// Checker for the binomial coefficient block: predicts each item's result and compares it.
`timescale 1ns / 1ps

module binomial_coefficient_checker import bc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire rsp_type rsp_data,
   output int           mismatch_count,
   output int           pending_count,
   output int           exact_count,
   output int           k_above_n_count,
   output int           overflow_count
);

   typedef struct {
      req_type item;
      rsp_type result;
   } coefficient_expectation_type;

   coefficient_expectation_type expected_coefficients[$];
   coefficient_expectation_type oldest;

   // Multiplicative rule with a product wide enough to hold value * (n - i) exactly.
   function automatic rsp_type predict_binomial(input req_type item);
      logic [PROD_WIDTH-1:0]  product;
      logic [PROD_WIDTH-1:0]  quotient;
      logic [VALUE_WIDTH-1:0] value;
      int                     steps;
      rsp_type                result;
      result.coefficient = '0;
      result.status      = STATUS_K_GT_N;
      if (item.k_chosen > item.n_total) begin
         return result;
      end
      steps = int'(item.k_chosen);
      if (int'(item.n_total) - int'(item.k_chosen) < steps) begin
         steps = int'(item.n_total) - int'(item.k_chosen);
      end
      value = 1;
      for (int i = 0; i < steps; i++) begin
         product  = PROD_WIDTH'(value) * PROD_WIDTH'(int'(item.n_total) - i);
         quotient = product / PROD_WIDTH'(i + 1);
         // stop at the first step whose value no longer fits
         if (quotient[PROD_WIDTH-1:VALUE_WIDTH] != '0) begin
            result.status = STATUS_OVERFLOW;
            return result;
         end
         value = quotient[VALUE_WIDTH-1:0];
      end
      result.coefficient = value;
      result.status      = STATUS_OK;
      return result;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count = mismatch_count + 1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_coefficients.delete();
         pending_count = 0;
      end else begin
         // compare the strobed result with the oldest expectation
         if (rsp_valid) begin
            if (expected_coefficients.size() == 0) begin
               report_mismatch($sformatf("result %0d status %0d with no item outstanding",
                                         rsp_data.coefficient, rsp_data.status));
            end else begin
               oldest = expected_coefficients.pop_front();
               if (rsp_data.coefficient !== oldest.result.coefficient) begin
                  report_mismatch($sformatf("C(%0d,%0d) coefficient %0d, predicted %0d",
                                            oldest.item.n_total, oldest.item.k_chosen,
                                            rsp_data.coefficient, oldest.result.coefficient));
               end
               if (rsp_data.status !== oldest.result.status) begin
                  report_mismatch($sformatf("C(%0d,%0d) status %0d, predicted %0d",
                                            oldest.item.n_total, oldest.item.k_chosen,
                                            rsp_data.status, oldest.result.status));
               end
               case (oldest.result.status)
                  STATUS_OK:       exact_count     = exact_count + 1;
                  STATUS_K_GT_N:   k_above_n_count = k_above_n_count + 1;
                  STATUS_OVERFLOW: overflow_count  = overflow_count + 1;
                  default: ;
               endcase
            end
         end
         // predict every item the block takes
         if (start && !busy) begin
            oldest.item   = req_data;
            oldest.result = predict_binomial(req_data);
            expected_coefficients.push_back(oldest);
         end
         pending_count = expected_coefficients.size();
      end
   end

endmodule

FILE: dv/binomial_coefficient_test.sv
// Top of the binomial coefficient testbench: clock, reset, item stimulus and verdict.
`timescale 1ns / 1ps

module binomial_coefficient_test;
   import bc_pkg::*;

   // The run sends 130 items; the cycle limit covers all of them at the slowest item's length, idles included.
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int DRAIN_CYCLES = 100;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   int mismatch_count;
   int pending_count;
   int exact_count;
   int k_above_n_count;
   int overflow_count;
   int cycle_count;

   binomial_coefficient DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   binomial_coefficient_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .exact_count     (exact_count),
      .k_above_n_count (k_above_n_count),
      .overflow_count  (overflow_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d items outstanding", pending_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // Offer one item after a random idle stretch, and hold it until the block takes it.
   task automatic send_nk(input int n, input int k, input int idle_pct);
      req_type item;
      item.n_total  = N_WIDTH'(n);
      item.k_chosen = N_WIDTH'(k);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Hold off until every outstanding item has its result.
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   // Random items, weighted toward small sets and the overflow boundary.
   task automatic run_phase(input int count, input int idle_pct);
      int n;
      int k;
      int pick;
      for (int j = 0; j < count; j++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            n = $urandom_range(24);
            k = $urandom_range(n + 2);
         end else if (pick < 65) begin
            n = $urandom_range(127);
            k = $urandom_range(127);
         end else if (pick < 85) begin
            n = $urandom_range(75, 58);
            k = n / 2 - 4 + $urandom_range(8);
         end else begin
            n = $urandom_range(127);
            case ($urandom_range(3))
               0: k = 0;
               1: k = n;
               2: k = (n > 0) ? n - 1 : 0;
               default: k = (n < 127) ? n + 1 : 1;
            endcase
         end
         send_nk(n, k, idle_pct);
      end
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, k past n, k of 0 or n, and the overflow boundary
      send_nk(0, 0, 12);
      send_nk(127, 0, 12);
      send_nk(127, 127, 12);
      send_nk(0, 127, 12);
      send_nk(126, 127, 12);
      send_nk(3, 4, 12);
      send_nk(1, 0, 12);
      send_nk(1, 1, 12);
      send_nk(2, 1, 12);
      send_nk(5, 2, 12);
      send_nk(20, 10, 12);
      send_nk(127, 1, 12);
      send_nk(127, 126, 12);
      send_nk(127, 10, 12);
      send_nk(127, 20, 12);
      send_nk(127, 63, 12);
      send_nk(127, 64, 12);
      send_nk(64, 32, 12);
      send_nk(66, 33, 12);
      send_nk(67, 33, 12);
      send_nk(67, 34, 12);
      send_nk(68, 34, 12);
      send_nk(68, 33, 12);
      wait_for_drain();

      run_phase(36, 12);
      wait_for_drain();
      run_phase(36, 64);
      wait_for_drain();
      run_phase(35, 0);
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Checked %0d results: %0d exact, %0d with k above n, %0d overflowed",
               exact_count + k_above_n_count + overflow_count, exact_count,
               k_above_n_count, overflow_count);
      $display("Sender idled 12%%, then 64%%, then never, draining before each phase");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
